/* hw/rtl/sepq_pkg.sv */
package sepq_pkg;

  // number of slots in the cell chain
  localparam int MAX_ENTRIES = 16;

  // count of stored events, holds 0 .. MAX_ENTRIES
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

  // capacity register width
  localparam int CAP_W = 5;

  // common width for comparing count against the capacity limit
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  // result field widths
  localparam int TIME_W   = 32;
  localparam int PAYLD_W  = 16;
  localparam int STATUS_W = 2;
  localparam int ECNT_W   = 5;

  // capacity register reset value
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_POP    = 1'b1
  } opcode_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // one stored event
  typedef struct packed {
    logic [TIME_W-1:0]  ev_time;
    logic [PAYLD_W-1:0] ev_payload;
  } slot_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic  ins;
    logic  pop;
    slot_t item;
  } cell_ctl_t;

endpackage

/* hw/rtl/sepq_cell.sv */
module sepq_cell (
  input  logic              clk,
  input  sepq_pkg::cell_ctl_t ctl,
  input  logic              unused_i,
  input  logic              left_later_i,
  input  sepq_pkg::slot_t   left_slot_i,
  input  sepq_pkg::slot_t   right_slot_i,
  output logic              later_o,
  output sepq_pkg::slot_t   slot_o
);
  import sepq_pkg::*;

  slot_t slot_r;

  // the new event belongs at or before this slot when the slot is free
  // or holds a strictly later time
  assign later_o = unused_i || (slot_r.ev_time > ctl.item.ev_time);
  assign slot_o  = slot_r;

  // insert: shift right past the insertion point, take the new event there
  // pop: shift left by one
  always_ff @(posedge clk) begin
    if (ctl.ins && later_o) begin
      slot_r <= left_later_i ? left_slot_i : ctl.item;
    end else if (ctl.pop) begin
      slot_r <= right_slot_i;
    end
  end

endmodule

/* hw/rtl/sorted_event_priority_queue.sv */
// Sorted event priority queue, earliest time first, stable for equal times.
// Input channel (in_valid / in_stall): in_opcode selects insert or pop;
// in_event_time and in_event_payload carry the event for an insert.
// Every accepted transaction gives exactly one result on the output channel
// (out_valid / out_stall): popped time and payload (zero for inserts and
// failed operations), a status code and the entry count after the operation.
// A result is registered and shown in the cycle after its transaction is
// accepted. One transaction is taken per cycle while in_stall is low; the
// whole operation is done in parallel by the chain of slot cells, each comparing
// its key with the new event and taking data from its left or right neighbor.
// The result register frees itself when taken, so a new transaction is taken
// in the same cycle the previous result leaves. While out_stall holds a
// pending result, in_stall is raised and the result stays unchanged.
// cfg_we writes cfg_data into the capacity limit (values above the slot count
// are clamped, zero refuses every insert). Reset empties the queue, clears
// the output channel and sets the limit to 16; no clearing pass is needed.
module sorted_event_priority_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [sepq_pkg::CAP_W-1:0]      cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_opcode,
  input  logic [sepq_pkg::TIME_W-1:0]     in_event_time,
  input  logic [sepq_pkg::PAYLD_W-1:0]    in_event_payload,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [sepq_pkg::TIME_W-1:0]     out_time,
  output logic [sepq_pkg::PAYLD_W-1:0]    out_payload,
  output logic [sepq_pkg::STATUS_W-1:0]   out_status,
  output logic [sepq_pkg::ECNT_W-1:0]     out_entry_count
);
  import sepq_pkg::*;

  logic [CAP_W-1:0]   cap_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               out_valid_r;
  logic [TIME_W-1:0]  out_time_r;
  logic [PAYLD_W-1:0] out_payload_r;
  status_t            out_status_r;
  logic [CNT_W-1:0]   out_cnt_r;

  logic [CMP_W-1:0]   eff_limit;
  logic               accept;
  logic               is_pop;
  logic               full;
  logic               empty;
  status_t            status_nxt;
  cell_ctl_t          ctl;

  slot_t              slots   [MAX_ENTRIES];
  logic               later   [MAX_ENTRIES];
  logic               unused  [MAX_ENTRIES];

  // handshake: stall only while a result is waiting and not taken
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign is_pop   = (in_opcode == OP_POP);

  // clamp the limit to the storage size
  always_comb begin
    if (CMP_W'(cap_r) > CMP_W'(MAX_ENTRIES)) begin
      eff_limit = CMP_W'(MAX_ENTRIES);
    end else begin
      eff_limit = CMP_W'(cap_r);
    end
  end

  assign full  = CMP_W'(cnt_r) >= eff_limit;
  assign empty = (cnt_r == '0);

  // operation broadcast to the chain
  assign ctl.ins             = accept && !is_pop && !full;
  assign ctl.pop             = accept && is_pop && !empty;
  assign ctl.item.ev_time    = in_event_time;
  assign ctl.item.ev_payload = in_event_payload;

  // next count and status
  always_comb begin
    cnt_nxt    = cnt_r;
    status_nxt = ST_OK;
    if (is_pop) begin
      if (empty) begin
        status_nxt = ST_EMPTY;
      end else begin
        cnt_nxt = cnt_r - CNT_W'(1);
      end
    end else begin
      if (full) begin
        status_nxt = ST_FULL;
      end else begin
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end
  end

  // chain of slot cells, slot zero holds the earliest event
  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    assign unused[i] = (CNT_W'(i) >= cnt_r);

    if (i == 0 && MAX_ENTRIES == 1) begin : g_only
      sepq_cell u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .unused_i     (unused[i]),
        .left_later_i (1'b0),
        .left_slot_i  (slots[i]),
        .right_slot_i (slots[i]),
        .later_o      (later[i]),
        .slot_o       (slots[i])
      );
    end else if (i == 0) begin : g_head
      sepq_cell u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .unused_i     (unused[i]),
        .left_later_i (1'b0),
        .left_slot_i  (slots[i]),
        .right_slot_i (slots[i+1]),
        .later_o      (later[i]),
        .slot_o       (slots[i])
      );
    end else if (i == MAX_ENTRIES - 1) begin : g_tail
      sepq_cell u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .unused_i     (unused[i]),
        .left_later_i (later[i-1]),
        .left_slot_i  (slots[i-1]),
        .right_slot_i (slots[i]),
        .later_o      (later[i]),
        .slot_o       (slots[i])
      );
    end else begin : g_mid
      sepq_cell u_cell (
        .clk          (clk),
        .ctl          (ctl),
        .unused_i     (unused[i]),
        .left_later_i (later[i-1]),
        .left_slot_i  (slots[i-1]),
        .right_slot_i (slots[i+1]),
        .later_o      (later[i]),
        .slot_o       (slots[i])
      );
    end
  end

  // control state: capacity, count, result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_data;
      end
      if (accept) begin
        cnt_r       <= cnt_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r <= status_nxt;
      out_cnt_r    <= cnt_nxt;
      if (ctl.pop) begin
        out_time_r    <= slots[0].ev_time;
        out_payload_r <= slots[0].ev_payload;
      end else begin
        out_time_r    <= '0;
        out_payload_r <= '0;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_time        = out_time_r;
  assign out_payload     = out_payload_r;
  assign out_status      = out_status_r;
  assign out_entry_count = ECNT_W'(out_cnt_r);

endmodule
